@@ rtl/core/tgs_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tgs_pkg: shared types and constants of the tridiagonal Gauss-Seidel solver
// Word layouts, controller states, datapath commands and status.
// ---------------------------------------------------------------------------
package tgs_pkg;

    localparam int DATA_W = 32;

    localparam logic CFG_MAX_ITER = 1'b0;
    localparam logic CFG_TOL      = 1'b1;

    localparam logic [15:0] MAX_ITER_RESET = 16'd100;
    localparam logic [30:0] TOL_RESET      = 31'd66;

    localparam logic [31:0] SAT_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN    = 32'h8000_0000;
    localparam logic [31:0] CHANGE_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [5:0]         row_index;
        logic signed [31:0] sub_coef;
        logic signed [31:0] diag_coef;
        logic signed [31:0] super_coef;
        logic signed [31:0] rhs_value;
        logic signed [31:0] initial_guess;
        logic               last_row;
    } t_in_word;

    typedef struct packed {
        logic [5:0]         out_row;
        logic signed [31:0] solution;
        logic               converged;
        logic [15:0]        sweeps_done;
        logic               divide_fault;
        logic               last_result;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SOLVE_INIT,
        ST_READ,
        ST_MUL_SUB,
        ST_MUL_SUP,
        ST_ACC,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_NEW,
        ST_CHG_START,
        ST_CHG_WAIT,
        ST_WRITEBACK,
        ST_SWEEP_END,
        ST_OUT_READ,
        ST_OUT_LOAD,
        ST_OUT_WAIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SOLVE_INIT,
        OP_READ,
        OP_MUL_SUB,
        OP_MUL_SUP,
        OP_ACC,
        OP_DIV_START,
        OP_NEW,
        OP_CHG_START,
        OP_WRITEBACK,
        OP_SWEEP_END,
        OP_OUT_READ,
        OP_OUT_LOAD
    } t_op;

    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic row_last;
        logic sweep_again;
        logic out_taken;
    } t_status;

endpackage

@@ rtl/core/tgs_div.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tgs_div: serial restoring divider
// Divides a 66-bit dividend by a 32-bit divisor, one quotient bit a cycle,
// flagging any quotient that does not fit in 32 bits.
// ---------------------------------------------------------------------------
module tgs_div import tgs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [65:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient,
    output logic        o_overflow
);

    logic        r_active;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_div;
    logic        r_ovf;

    logic [32:0] w_shift;
    logic        w_fit;
    logic        w_big;

    assign w_shift = {r_rem, r_quo[31]};
    assign w_fit   = (w_shift >= {1'b0, r_div});
    // A quotient of 2^32 or more is seen up front from the upper half alone.
    assign w_big   = (i_dividend[65:32] >= {2'b00, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else if (i_start) begin
            r_active <= 1'b1;
            r_cnt    <= w_big ? 6'd0 : 6'd32;
        end else if (r_active && (r_cnt != 6'd0)) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ovf <= w_big;
            r_div <= i_divisor;
            r_rem <= i_dividend[63:32];
            r_quo <= i_dividend[31:0];
        end else if (r_active && (r_cnt != 6'd0)) begin
            r_rem <= w_fit ? 32'(w_shift - {1'b0, r_div}) : w_shift[31:0];
            r_quo <= {r_quo[30:0], w_fit};
        end
    end

    assign o_done     = r_active && (r_cnt == 6'd0);
    assign o_quotient = r_quo;
    assign o_overflow = r_ovf;

endmodule

@@ rtl/core/tgs_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tgs_datapath: row stores, multiply-accumulate and update arithmetic
// Holds the system, forms each row update, the relative change and the
// result words, under command of the controller.
// ---------------------------------------------------------------------------
module tgs_datapath import tgs_pkg::*; #(
    parameter int ROWS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  t_in_word    i_in_word,
    input  logic [15:0] i_max_iter,
    input  logic [30:0] i_tol,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word
);

    localparam int IW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(ROWS - 1);

    logic [31:0] r_sub_mem  [ROWS];
    logic [31:0] r_diag_mem [ROWS];
    logic [31:0] r_sup_mem  [ROWS];
    logic [31:0] r_rhs_mem  [ROWS];
    logic [31:0] r_x_mem    [ROWS];

    logic signed [31:0] r_rd_sub, r_rd_diag, r_rd_sup, r_rd_rhs, r_rd_x, r_rd_xn;
    logic [IW-1:0]      r_idx;
    logic signed [31:0] r_x_prev;
    logic signed [63:0] r_prod;
    logic signed [49:0] r_acc;
    logic               r_neg;
    logic               r_den_zero;
    logic signed [31:0] r_new;
    logic [32:0]        r_ad;
    logic               r_an_zero;
    logic [31:0]        r_big;
    logic [15:0]        r_n;
    logic               r_fault;
    logic               r_out_valid;
    t_out_word          r_out;

    logic               w_row_last;
    logic               w_load_ok;
    logic [IW-1:0]      w_load_idx;
    logic [IW-1:0]      w_next_idx;
    logic signed [31:0] w_mul_a, w_mul_b;
    logic signed [63:0] w_mul_p;
    logic signed [49:0] w_prod_fl;
    logic signed [49:0] w_rhs_ext;
    logic [49:0]        w_acc_mag;
    logic [31:0]        w_diag_mag;
    logic signed [32:0] w_diff;
    logic [32:0]        w_ad;
    logic [31:0]        w_an;
    logic               w_div_start;
    logic [65:0]        w_dividend;
    logic [31:0]        w_divisor;
    logic               w_div_done;
    logic [31:0]        w_quo;
    logic               w_ovf;
    logic signed [31:0] w_new;
    logic [31:0]        w_change;
    logic               w_taken;
    logic               w_x_we;
    logic [IW-1:0]      w_x_waddr;
    logic [31:0]        w_x_wdata;

    assign w_row_last = (r_idx == LAST_IDX);
    assign w_load_ok  = (int'(i_in_word.row_index) < ROWS);
    assign w_load_idx = i_in_word.row_index[IW-1:0];
    assign w_next_idx = w_row_last ? r_idx : r_idx + IW'(1);
    assign w_taken    = r_out_valid && i_out_ready;

    // One multiplier serves both neighbour products.
    assign w_mul_a   = (i_cmd.op == OP_MUL_SUB) ? r_rd_sub : r_rd_sup;
    assign w_mul_b   = (i_cmd.op == OP_MUL_SUB) ? r_x_prev : r_rd_xn;
    assign w_mul_p   = w_mul_a * w_mul_b;
    assign w_prod_fl = {{2{r_prod[63]}}, r_prod[63:16]};
    assign w_rhs_ext = {{18{r_rd_rhs[31]}}, r_rd_rhs};

    assign w_acc_mag  = r_acc[49] ? 50'(-r_acc) : 50'(r_acc);
    assign w_diag_mag = r_rd_diag[31] ? 32'(-r_rd_diag) : 32'(r_rd_diag);
    assign w_diff     = {r_rd_x[31], r_rd_x} - {r_new[31], r_new};
    assign w_ad       = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
    assign w_an       = r_new[31] ? 32'(-r_new) : 32'(r_new);

    assign w_div_start = (i_cmd.op == OP_DIV_START) || (i_cmd.op == OP_CHG_START);
    assign w_dividend  = (i_cmd.op == OP_DIV_START) ? {w_acc_mag, 16'h0000}
                                                    : {17'h0, w_ad, 16'h0000};
    assign w_divisor   = (i_cmd.op == OP_DIV_START) ? w_diag_mag : w_an;

    tgs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo),
        .o_overflow (w_ovf)
    );

    always_comb begin
        if (r_den_zero) begin
            if (r_acc > 50'sd0) begin
                w_new = SAT_MAX;
            end else if (r_acc < 50'sd0) begin
                w_new = SAT_MIN;
            end else begin
                w_new = '0;
            end
        end else if (w_ovf) begin
            w_new = r_neg ? SAT_MIN : SAT_MAX;
        end else if (!r_neg) begin
            w_new = w_quo[31] ? SAT_MAX : w_quo;
        end else begin
            w_new = (w_quo > SAT_MIN) ? SAT_MIN : 32'(-w_quo);
        end
    end

    always_comb begin
        if (r_an_zero) begin
            w_change = (r_ad == 33'd0) ? 32'd0 : CHANGE_MAX;
        end else begin
            w_change = w_ovf ? CHANGE_MAX : w_quo;
        end
    end

    assign w_x_we    = ((i_cmd.op == OP_LOAD) && w_load_ok) || (i_cmd.op == OP_WRITEBACK);
    assign w_x_waddr = (i_cmd.op == OP_LOAD) ? w_load_idx : r_idx;
    assign w_x_wdata = (i_cmd.op == OP_LOAD) ? i_in_word.initial_guess : r_new;

    always_ff @(posedge i_clk) begin
        if ((i_cmd.op == OP_LOAD) && w_load_ok) begin
            r_sub_mem[w_load_idx]  <= i_in_word.sub_coef;
            r_diag_mem[w_load_idx] <= i_in_word.diag_coef;
            r_sup_mem[w_load_idx]  <= i_in_word.super_coef;
            r_rhs_mem[w_load_idx]  <= i_in_word.rhs_value;
        end
        if (w_x_we) begin
            r_x_mem[w_x_waddr] <= w_x_wdata;
        end
        if (i_cmd.op == OP_READ) begin
            r_rd_sub  <= r_sub_mem[r_idx];
            r_rd_diag <= r_diag_mem[r_idx];
            r_rd_sup  <= r_sup_mem[r_idx];
            r_rd_rhs  <= r_rhs_mem[r_idx];
            r_rd_x    <= r_x_mem[r_idx];
            r_rd_xn   <= r_x_mem[w_next_idx];
        end else if (i_cmd.op == OP_OUT_READ) begin
            r_rd_x <= r_x_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_MUL_SUB: begin
                r_prod <= w_mul_p;
            end
            OP_MUL_SUP: begin
                r_prod <= w_mul_p;
                r_acc  <= w_rhs_ext - ((r_idx != '0) ? w_prod_fl : 50'sd0);
            end
            OP_ACC: begin
                r_acc <= r_acc - (w_row_last ? 50'sd0 : w_prod_fl);
            end
            OP_DIV_START: begin
                r_neg      <= r_acc[49] ^ r_rd_diag[31];
                r_den_zero <= (r_rd_diag == 32'sd0);
            end
            OP_NEW: begin
                r_new <= w_new;
            end
            OP_CHG_START: begin
                r_ad      <= w_ad;
                r_an_zero <= (w_an == 32'd0);
            end
            OP_WRITEBACK: begin
                r_x_prev <= r_new;
            end
            OP_OUT_LOAD: begin
                r_out.out_row      <= 6'(r_idx);
                r_out.solution     <= r_rd_x;
                r_out.converged    <= (r_big <= {1'b0, i_tol});
                r_out.sweeps_done  <= r_n - 16'd1;
                r_out.divide_fault <= r_fault;
                r_out.last_result  <= w_row_last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_big       <= '0;
            r_n         <= '0;
            r_fault     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_SOLVE_INIT: begin
                    r_fault <= 1'b0;
                    r_n     <= 16'd1;
                    r_idx   <= '0;
                    r_big   <= '0;
                end
                OP_NEW: begin
                    if (r_den_zero) begin
                        r_fault <= 1'b1;
                    end
                end
                OP_WRITEBACK: begin
                    if (w_change > r_big) begin
                        r_big <= w_change;
                    end
                    if (!w_row_last) begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                OP_SWEEP_END: begin
                    r_n   <= r_n + 16'd1;
                    r_idx <= '0;
                    if (o_status.sweep_again) begin
                        r_big <= '0;
                    end
                end
                OP_OUT_LOAD: begin
                    r_out_valid <= 1'b1;
                end
                default: begin
                end
            endcase
            if (w_taken) begin
                r_out_valid <= 1'b0;
                if (!w_row_last) begin
                    r_idx <= r_idx + IW'(1);
                end
            end
        end
    end

    assign o_status.div_done    = w_div_done;
    assign o_status.row_last    = w_row_last;
    assign o_status.sweep_again = (r_big > {1'b0, i_tol})
                                  && (({1'b0, r_n} + 17'd1) < {1'b0, i_max_iter});
    assign o_status.out_taken   = w_taken;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

@@ rtl/core/tgs_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tgs_ctrl: solver sequencer
// Steps the datapath through loading, the per-row update of each sweep,
// the convergence decision and the delivery of the results.
// ---------------------------------------------------------------------------
module tgs_ctrl import tgs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_last_row,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_last_row) begin
                    n_state = ST_SOLVE_INIT;
                end
            end
            ST_SOLVE_INIT: n_state = ST_READ;
            ST_READ:       n_state = ST_MUL_SUB;
            ST_MUL_SUB:    n_state = ST_MUL_SUP;
            ST_MUL_SUP:    n_state = ST_ACC;
            ST_ACC:        n_state = ST_DIV_START;
            ST_DIV_START:  n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (i_status.div_done) begin
                    n_state = ST_NEW;
                end
            end
            ST_NEW:        n_state = ST_CHG_START;
            ST_CHG_START:  n_state = ST_CHG_WAIT;
            ST_CHG_WAIT: begin
                if (i_status.div_done) begin
                    n_state = ST_WRITEBACK;
                end
            end
            ST_WRITEBACK: begin
                n_state = i_status.row_last ? ST_SWEEP_END : ST_READ;
            end
            ST_SWEEP_END: begin
                n_state = i_status.sweep_again ? ST_READ : ST_OUT_READ;
            end
            ST_OUT_READ:   n_state = ST_OUT_LOAD;
            ST_OUT_LOAD:   n_state = ST_OUT_WAIT;
            ST_OUT_WAIT: begin
                if (i_status.out_taken) begin
                    n_state = i_status.row_last ? ST_IDLE : ST_OUT_READ;
                end
            end
            default:       n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op       = OP_NOP;
        o_cmd.in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                end
            end
            ST_SOLVE_INIT: o_cmd.op = OP_SOLVE_INIT;
            ST_READ:       o_cmd.op = OP_READ;
            ST_MUL_SUB:    o_cmd.op = OP_MUL_SUB;
            ST_MUL_SUP:    o_cmd.op = OP_MUL_SUP;
            ST_ACC:        o_cmd.op = OP_ACC;
            ST_DIV_START:  o_cmd.op = OP_DIV_START;
            ST_NEW:        o_cmd.op = OP_NEW;
            ST_CHG_START:  o_cmd.op = OP_CHG_START;
            ST_WRITEBACK:  o_cmd.op = OP_WRITEBACK;
            ST_SWEEP_END:  o_cmd.op = OP_SWEEP_END;
            ST_OUT_READ:   o_cmd.op = OP_OUT_READ;
            ST_OUT_LOAD:   o_cmd.op = OP_OUT_LOAD;
            default:       o_cmd.op = OP_NOP;
        endcase
    end

endmodule

@@ rtl/core/tridiagonal_gauss_seidel_solver.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tridiagonal_gauss_seidel_solver: fixed-point tridiagonal system solver
// Loads a tridiagonal system row by row and solves it by Gauss-Seidel
// sweeps in signed Q16.16, then delivers one solution word per row.
// ---------------------------------------------------------------------------
// Each input word loads one row and is taken while the block is idle. The
// word with last_row set starts the solve, during which no input is taken.
// Each row of every sweep reads the row, forms the two neighbour products
// on one shared multiplier and accumulates them, runs a bit-serial divider
// twice (the update quotient and the relative change), then settles the
// new value and writes it back. A quotient too large for 32 bits is seen
// at the start and ends its run at once, which shortens that row. Each
// sweep ends with the convergence decision, and the solve opens with an
// initialisation step. The divider runs take most of the solve time. The
// results then leave one word at a time, each held until the output side
// takes it. Sweeping stops when the largest relative change is at most
// the tolerance, or when max_iterations - 1 sweeps have been run; at least
// one is always run. A zero diagonal sets divide_fault and saturates the
// row's value, or gives zero when the row's numerator is zero as well.
// Configuration writes go through the plain write port and must be made
// while the block is idle.
// ---------------------------------------------------------------------------
module tridiagonal_gauss_seidel_solver import tgs_pkg::*; #(
    parameter int ROWS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [30:0] i_cfg_data
);

    // Configuration registers: the iteration limit and the change tolerance.
    logic [15:0] r_max_iter;
    logic [30:0] r_tol;

    t_cmd    w_cmd;
    t_status w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= MAX_ITER_RESET;
            r_tol      <= TOL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_ITER: r_max_iter <= i_cfg_data[15:0];
                CFG_TOL:      r_tol      <= i_cfg_data;
                default:      r_tol      <= r_tol;
            endcase
        end
    end

    // The sequencer decides the step; the datapath holds every value.
    tgs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last_row (i_in_word.last_row),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tgs_datapath #(
        .ROWS (ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_word   (i_in_word),
        .i_max_iter  (r_max_iter),
        .i_tol       (r_tol),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    assign o_in_ready = w_cmd.in_ready;

`ifndef NO_ASSERTIONS
    // Loading and delivering never overlap.
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input ready while a result word is pending");

    // Every delivered word reports at least one sweep.
    a_sweeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.sweeps_done != 16'd0))
        else $error("result word reports no sweep");

    // Once the final word is taken the block is ready for a new system.
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_word.last_result) |=> o_in_ready)
        else $error("block not idle after the final result word");
`endif

endmodule
